// ===== hdl/wppr_pkg.sv =====
// Package for the windowed peak-to-peak rate block: widths, sizes and reset values.
package wppr_pkg;

    localparam int WINDOW   = 128;
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int SAMPLE_W = 10;
    localparam int NUM_W    = 16;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [NUM_W-1:0] NUMERATOR_RESET = NUM_W'(60 * 100);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = {SAMPLE_W{1'b1}};

    // tuser code of the input transfer
    localparam logic MODE_SAMPLE   = 1'b0;
    localparam logic MODE_EVALUATE = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

endpackage

// ===== hdl/window_peak_to_peak_rate_core.sv =====
// Windowed peak-to-peak range and rate: sample ring, min/max scan and serial divider.
//
// Usage:
//   Input channel (s_): one transfer per item. s_tuser[0] selects the kind:
//   0 stores s_tdata[9:0] as a new sample in the ring (newest 128 kept),
//   1 evaluates the window. Sample transfers give no output transfer.
//   Output channel (m_): one transfer per evaluate, carrying the range
//   (max - min over the stored samples), rate = cfg numerator / range and
//   a zero_range flag (range 0, rate forced to 0, no division done).
//   cfg_wen/cfg_wdata write the 16-bit rate numerator (reset 6000); write
//   only while the block is idle.
// Operation:
//   A sample keeps the block idle; s_tready stays high after it.
//   An evaluate reads every stored entry in turn through the ring's single
//   read port, waits out the read latency, forms the range, runs the
//   restoring divider over the 16 numerator bits and loads the output.
//   A zero range skips the divider.
// Reset clears write slot, fill count, numerator and the output valid flag;
// the ring contents are not cleared (only filled entries are read).
// When the receiver stalls the finished result waits in the output
// register; samples are still accepted, a later evaluate waits for it.
module window_peak_to_peak_rate_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] sample, [15:10] ignored
    input  logic [0:0]  s_tuser,   // [0] mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] range, [25:10] rate, [31:26] zero
    output logic [0:0]  m_tuser,   // [0] zero_range
    // numerator register
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);

    localparam int SLOT_W    = wppr_pkg::SLOT_W;
    localparam int FILL_W    = wppr_pkg::FILL_W;
    localparam int SAMPLE_W  = wppr_pkg::SAMPLE_W;
    localparam int NUM_W     = wppr_pkg::NUM_W;
    localparam int DIV_CNT_W = wppr_pkg::DIV_CNT_W;

    // sample ring, one write port (IDLE) and one read port (SCAN)
    logic [SAMPLE_W-1:0] ring [wppr_pkg::WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;

    wppr_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0]    write_slot_reg, write_slot_next;
    logic [FILL_W-1:0]    fill_count_reg, fill_count_next;
    logic [NUM_W-1:0]     numerator_reg;

    logic [FILL_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [SAMPLE_W-1:0]  hi_reg, hi_next;
    logic [SAMPLE_W-1:0]  lo_reg, lo_next;

    logic [SAMPLE_W-1:0]  range_reg, range_next;
    logic                 zero_reg, zero_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]  m_range_reg, m_range_next;
    logic [NUM_W-1:0]     m_rate_reg, m_rate_next;
    logic                 m_zero_reg, m_zero_next;

    logic                 s_xfer;
    logic                 wr_en;
    logic                 rd_en;
    logic [SAMPLE_W:0]    rem_shift;
    logic [SAMPLE_W:0]    rem_diff;
    logic                 rem_ge;

    assign s_tready = (state_reg == wppr_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign wr_en    = s_xfer && (s_tuser[0] == wppr_pkg::MODE_SAMPLE);
    assign rd_en    = (state_reg == wppr_pkg::ST_SCAN) && (scan_idx_reg < fill_count_reg);

    // restoring divider step
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, range_reg};
    assign rem_ge    = (rem_shift >= {1'b0, range_reg});

    // ring memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[write_slot_reg] <= s_tdata[SAMPLE_W-1:0];
        end
        rd_data_reg <= ring[scan_idx_reg[SLOT_W-1:0]];
    end

    always_comb begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        fill_count_next = fill_count_reg;
        scan_idx_next   = scan_idx_reg;
        rd_pend_next    = rd_en;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        range_next      = range_reg;
        zero_next       = zero_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_range_next    = m_range_reg;
        m_rate_next     = m_rate_reg;
        m_zero_next     = m_zero_reg;

        unique case (state_reg)
            wppr_pkg::ST_IDLE: begin
                if (wr_en) begin
                    if (write_slot_reg == SLOT_W'(wppr_pkg::WINDOW - 1)) begin
                        write_slot_next = '0;
                    end else begin
                        write_slot_next = write_slot_reg + 1'b1;
                    end
                    if (fill_count_reg < FILL_W'(wppr_pkg::WINDOW)) begin
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                end else if (s_xfer) begin
                    scan_idx_next = '0;
                    hi_next       = '0;
                    lo_next       = wppr_pkg::SAMPLE_MAX;
                    state_next    = wppr_pkg::ST_SCAN;
                end
            end
            wppr_pkg::ST_SCAN: begin
                if (rd_en) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (rd_pend_reg) begin
                    if (rd_data_reg > hi_reg) hi_next = rd_data_reg;
                    if (rd_data_reg < lo_reg) lo_next = rd_data_reg;
                end
                // all reads issued and folded in
                if (!rd_en && !rd_pend_reg) begin
                    if (fill_count_reg == '0) begin
                        range_next = '0;
                    end else begin
                        range_next = hi_reg - lo_reg;
                    end
                    quo_next     = numerator_reg;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    if ((fill_count_reg == '0) || (hi_reg == lo_reg)) begin
                        zero_next  = 1'b1;
                        quo_next   = '0;
                        state_next = wppr_pkg::ST_HOLD;
                    end else begin
                        zero_next  = 1'b0;
                        state_next = wppr_pkg::ST_DIV;
                    end
                end
            end
            wppr_pkg::ST_DIV: begin
                rem_next     = rem_ge ? rem_diff[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
                quo_next     = {quo_reg[NUM_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                    state_next = wppr_pkg::ST_HOLD;
                end
            end
            wppr_pkg::ST_HOLD: begin
                // wait for a free output register
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_range_next  = range_reg;
                    m_rate_next   = quo_reg;
                    m_zero_next   = zero_reg;
                    state_next    = wppr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wppr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wppr_pkg::ST_IDLE;
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            numerator_reg  <= wppr_pkg::NUMERATOR_RESET;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            fill_count_reg <= fill_count_next;
            rd_pend_reg    <= rd_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wen) begin
                numerator_reg <= cfg_wdata;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        range_reg    <= range_next;
        zero_reg     <= zero_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        m_range_reg  <= m_range_next;
        m_rate_reg   <= m_rate_next;
        m_zero_reg   <= m_zero_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_rate_reg, m_range_reg};
    assign m_tuser  = m_zero_reg;

    // fill count saturates at the ring size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(wppr_pkg::WINDOW))
        else $error("fill count beyond ring size");

    // an evaluate blocks the input on the following cycle
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_tuser[0] == wppr_pkg::MODE_EVALUATE) |=> !s_tready)
        else $error("input ready right after evaluate");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wppr_pkg::ST_DIV) |-> (rem_reg < range_reg))
        else $error("divider remainder out of range");

    // a flagged result carries range and rate of zero
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_zero_reg |-> (m_range_reg == '0) && (m_rate_reg == '0))
        else $error("zero_range result with nonzero payload");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for window_peak_to_peak_rate_core: directed and random stream traffic.
`timescale 1ns / 1ps

module tb;

    // Pause after the last expected result before touching the register or ending:
    // covers a sample still in flight and an evaluate's worst case.
    localparam int SETTLE_CYCLES = 200;

    // One result transfer as predicted
    typedef struct packed {
        logic [wppr_pkg::SAMPLE_W-1:0] range_val;
        logic [wppr_pkg::NUM_W-1:0]    rate;
        logic                          zero_range;
    } peak_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [9:0] sample, [15:10] padding
    logic [0:0]  s_tuser = '0;     // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [9:0] range, [25:10] rate, [31:26] zero fill
    logic [0:0]  m_tuser;          // [0] zero_range
    logic        cfg_wen = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // Predictor state: its own ring, write pointer, fill level and numerator
    logic [wppr_pkg::SAMPLE_W-1:0] ring_model [wppr_pkg::WINDOW];
    logic [wppr_pkg::SLOT_W-1:0]   slot_model;
    logic [wppr_pkg::FILL_W-1:0]   fill_model;
    logic [wppr_pkg::NUM_W-1:0]    numerator_model;

    peak_result_t expected_results [$];
    peak_result_t want;

    // Idle rates in percent, changed per test
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    int mismatch_count = 0;
    int results_seen = 0;
    int samples_sent = 0;
    int evaluates_sent = 0;
    int zero_range_seen = 0;
    int numerator_writes = 0;

    window_peak_to_peak_rate_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 0;
    end

    // Receiver backpressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_window_model();
        slot_model = '0;
        fill_model = '0;
        numerator_model = wppr_pkg::NUMERATOR_RESET;
    endfunction

    function automatic void store_sample(input logic [wppr_pkg::SAMPLE_W-1:0] smp);
        ring_model[slot_model] = smp;
        slot_model = (slot_model == wppr_pkg::SLOT_W'(wppr_pkg::WINDOW - 1)) ?
                     '0 : slot_model + 1'b1;
        if (fill_model < wppr_pkg::FILL_W'(wppr_pkg::WINDOW))
            fill_model = fill_model + 1'b1;
    endfunction

    // Max/min over the filled entries; range 0 (empty or flat) skips the divide
    function automatic peak_result_t evaluate_window();
        logic [wppr_pkg::SAMPLE_W-1:0] hi;
        logic [wppr_pkg::SAMPLE_W-1:0] lo;
        peak_result_t r;
        hi = '0;
        lo = wppr_pkg::SAMPLE_MAX;
        for (int k = 0; k < int'(fill_model); k++) begin
            if (ring_model[k] > hi) hi = ring_model[k];
            if (ring_model[k] < lo) lo = ring_model[k];
        end
        r.range_val = (fill_model == 0) ? '0 : hi - lo;
        if (r.range_val == 0) begin
            r.rate = '0;
            r.zero_range = 1'b1;
        end else begin
            r.rate = wppr_pkg::NUM_W'(numerator_model / r.range_val);
            r.zero_range = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Pre-edge values are read here, so DUT updates at this edge don't leak in
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result transfer with none pending (range %0d)",
                                        m_tdata[wppr_pkg::SAMPLE_W-1:0]));
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[wppr_pkg::SAMPLE_W-1:0] !== want.range_val)
                    flag_mismatch($sformatf("range %0d, want %0d",
                                            m_tdata[wppr_pkg::SAMPLE_W-1:0],
                                            want.range_val));
                if (m_tdata[wppr_pkg::SAMPLE_W+wppr_pkg::NUM_W-1:wppr_pkg::SAMPLE_W]
                    !== want.rate)
                    flag_mismatch($sformatf("rate %0d, want %0d (range %0d)",
                        m_tdata[wppr_pkg::SAMPLE_W+wppr_pkg::NUM_W-1:wppr_pkg::SAMPLE_W],
                        want.rate, want.range_val));
                if (m_tuser[0] !== want.zero_range)
                    flag_mismatch($sformatf("zero_range %0b, want %0b",
                                            m_tuser[0], want.zero_range));
                if (want.zero_range)
                    zero_range_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; each is entered and left right after a rising edge
    // ------------------------------------------------------------------
    task automatic send_item(input logic mode, input logic [wppr_pkg::SAMPLE_W-1:0] smp,
                             input logic [15-wppr_pkg::SAMPLE_W:0] pad = '0);
        // idle cycle by cycle at the sender's idle rate
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {pad, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // transfer taken at this edge
        if (mode == wppr_pkg::MODE_SAMPLE) begin
            store_sample(smp);
            samples_sent++;
        end else begin
            expected_results.push_back(evaluate_window());
            evaluates_sent++;
        end
    endtask

    // Sender holds off until every pending result is back, then lets the block settle
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_numerator(input logic [wppr_pkg::NUM_W-1:0] value);
        pause_until_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        numerator_model = value;
        numerator_writes++;
    endtask

    function automatic logic [wppr_pkg::NUM_W-1:0] pick_numerator();
        case ($urandom_range(0, 3))
            0:       return wppr_pkg::NUM_W'($urandom_range(1, 65535));
            1:       return wppr_pkg::NUM_W'($urandom_range(1, 1023));
            2:       return wppr_pkg::NUMERATOR_RESET;
            default: return {wppr_pkg::NUM_W{1'b1}};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty window, then a window of one and of several equal samples
    task automatic test_empty_and_flat();
        send_item(wppr_pkg::MODE_EVALUATE, '0);
        send_item(wppr_pkg::MODE_SAMPLE, 10'd512);
        send_item(wppr_pkg::MODE_EVALUATE, '0);
        send_item(wppr_pkg::MODE_SAMPLE, 10'd512);
        send_item(wppr_pkg::MODE_SAMPLE, 10'd512);
        send_item(wppr_pkg::MODE_EVALUATE, 10'd1023);   // sample field ignored on evaluate
    endtask

    // Full-scale range, padding bits set, numerator at 65535, 0 and 1
    task automatic test_extremes();
        send_item(wppr_pkg::MODE_SAMPLE, 10'd0);
        send_item(wppr_pkg::MODE_SAMPLE, wppr_pkg::SAMPLE_MAX);
        send_item(wppr_pkg::MODE_EVALUATE, '0);
        send_item(wppr_pkg::MODE_SAMPLE, 10'd7, '1);    // upper tdata bits must be dropped
        send_item(wppr_pkg::MODE_EVALUATE, '0);
        write_numerator({wppr_pkg::NUM_W{1'b1}});
        send_item(wppr_pkg::MODE_EVALUATE, '0);
        write_numerator('0);
        send_item(wppr_pkg::MODE_EVALUATE, '0);         // nonzero range, rate 0, flag clear
        write_numerator(wppr_pkg::NUM_W'(1));
        send_item(wppr_pkg::MODE_EVALUATE, '0);
    endtask

    // Samples drawn from bands of varying width so the window's range sweeps from
    // 0 (flat) through 1 up to full scale; a few out-of-band samples as noise.
    task automatic test_random_windows(input int n_items, input int tx_pct, input int rx_pct);
        int band_lo;
        int band_hi;
        int band_left;
        int half;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        band_lo = 0;
        band_hi = 0;
        band_left = 0;
        half = n_items / 2;
        write_numerator(pick_numerator());
        for (int i = 0; i < n_items; i++) begin
            if (i == half)
                write_numerator(pick_numerator());
            if (band_left == 0) begin
                band_lo = $urandom_range(0, 1023);
                case ($urandom_range(0, 3))
                    0:       band_hi = band_lo;
                    1:       band_hi = band_lo + 1;
                    2:       band_hi = band_lo + $urandom_range(2, 15);
                    default: band_hi = band_lo + $urandom_range(16, 1023);
                endcase
                if (band_hi > 1023) band_hi = 1023;
                band_left = $urandom_range(1, 200);
            end
            band_left--;
            if ($urandom_range(0, 99) < 20)
                send_item(wppr_pkg::MODE_EVALUATE,
                          wppr_pkg::SAMPLE_W'($urandom_range(0, 1023)));
            else if ($urandom_range(0, 99) < 5)
                send_item(wppr_pkg::MODE_SAMPLE,
                          wppr_pkg::SAMPLE_W'($urandom_range(0, 1023)));
            else
                send_item(wppr_pkg::MODE_SAMPLE,
                          wppr_pkg::SAMPLE_W'($urandom_range(band_lo, band_hi)));
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        clear_window_model();

        test_empty_and_flat();
        test_extremes();
        test_random_windows(470, 28, 51);
        test_random_windows(470, 51, 28);
        test_random_windows(460, 0, 0);

        pause_until_drained();
        $display("Covered %0d samples and %0d evaluates; %0d results checked, %0d %s",
                 samples_sent, evaluates_sent, results_seen, zero_range_seen,
                 "with zero range.");
        $display("Numerator rewritten %0d times; %0d mismatches.",
                 numerator_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("Timeout with %0d results still pending.", expected_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/wppr_pkg.sv
hdl/window_peak_to_peak_rate_core.sv
verif/tb.sv
